// ===== src/mcst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the timer channel bank.
// Used by mcst_front, mcst_back and multi_channel_soft_timer_bank.
package mcst_pkg;

  // field widths fixed by the item format
  localparam int OPCODE_W = 3;
  localparam int ID_W     = 8;
  localparam int CHAN_W   = 6;
  localparam int VAL_W    = 16;

  // default channel count of the bank
  localparam int CHANNEL_COUNT_DEF = 8;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // raw opcodes on the input channel
  localparam logic [OPCODE_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CONFIG = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_START  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RESET  = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_FREE   = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd6;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // classified command; CMD_BAD covers the unused opcode and ids out of range
  typedef enum logic [2:0] {
    CMD_ALLOC,
    CMD_CONFIG,
    CMD_START,
    CMD_STOP,
    CMD_RESET,
    CMD_FREE,
    CMD_TICK,
    CMD_BAD
  } cmd_t;

  // one queued command
  typedef struct packed {
    cmd_t              cmd;
    logic [CHAN_W-1:0] chan;
    logic [VAL_W-1:0]  max_value;
    logic              one_shot;
  } cmd_item_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } seq_state_t;

endpackage

// ===== src/mcst_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transfers, classifies them and queues them.
// Depends on mcst_pkg.
module mcst_front #(
  parameter int CHANNEL_COUNT = mcst_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcst_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [mcst_pkg::ID_W-1:0]     in_timer_id,
  input  logic [mcst_pkg::VAL_W-1:0]    in_max_value,
  input  logic                          in_one_shot,
  output logic                          q_valid,
  output mcst_pkg::cmd_item_t           q_item,
  input  logic                          q_pop
);
  import mcst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_item_t        fifo_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  cmd_item_t        dec_item;
  logic             in_range;
  logic             push;

  // id range check
  assign in_range = ({1'b0, in_timer_id} < (ID_W + 1)'(CHANNEL_COUNT));

  // classify the incoming command
  always_comb begin
    dec_item.chan      = in_timer_id[CHAN_W-1:0];
    dec_item.max_value = in_max_value;
    dec_item.one_shot  = in_one_shot;
    unique case (in_opcode)
      OP_ALLOC:  dec_item.cmd = CMD_ALLOC;
      OP_CONFIG: dec_item.cmd = in_range ? CMD_CONFIG : CMD_BAD;
      OP_START:  dec_item.cmd = in_range ? CMD_START  : CMD_BAD;
      OP_STOP:   dec_item.cmd = in_range ? CMD_STOP   : CMD_BAD;
      OP_RESET:  dec_item.cmd = in_range ? CMD_RESET  : CMD_BAD;
      OP_FREE:   dec_item.cmd = in_range ? CMD_FREE   : CMD_BAD;
      OP_TICK:   dec_item.cmd = CMD_TICK;
      default:   dec_item.cmd = CMD_BAD;
    endcase
  end

  // queue handshake
  assign in_ready = (fill_r != CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill_r != '0);
  assign q_item   = fifo_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

// ===== src/mcst_back.sv =====
`timescale 1ns / 1ps
// Back end: channel state, command execution, tick scan and result register.
// Depends on mcst_pkg.
module mcst_back #(
  parameter int CHANNEL_COUNT = mcst_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mcst_pkg::cmd_item_t         q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [mcst_pkg::CHAN_W-1:0] out_channel,
  output logic                        out_ok,
  output logic                        out_last
);
  import mcst_pkg::*;

  localparam int IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SCAN_W = $clog2(CHANNEL_COUNT + 1);

  // per channel flags
  logic [CHANNEL_COUNT-1:0] alloc_r, alloc_nxt;
  logic [CHANNEL_COUNT-1:0] run_r, run_nxt;
  logic [CHANNEL_COUNT-1:0] shot_r, shot_nxt;
  // count and limit memory entries hold a written value; otherwise they read as zero
  logic [CHANNEL_COUNT-1:0] cvld_r, cvld_nxt;
  logic [CHANNEL_COUNT-1:0] lvld_r, lvld_nxt;

  // count and limit memories
  logic [VAL_W-1:0] cnt_mem [CHANNEL_COUNT];
  logic [VAL_W-1:0] lim_mem [CHANNEL_COUNT];
  logic [VAL_W-1:0] cnt_q_r;
  logic [VAL_W-1:0] lim_q_r;

  seq_state_t        st_r, st_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;
  logic              hold_vld_r, hold_vld_nxt;
  logic [IDX_W-1:0]  hold_ch_r, hold_ch_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [CHAN_W-1:0] out_channel_r, out_channel_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              scan_done;
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  cmd_idx;
  logic              scan_active;
  logic [VAL_W-1:0]  cnt_val;
  logic [VAL_W-1:0]  lim_val;
  logic              expire;
  logic              eval_go;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              cnt_we;
  logic              lim_we;

  assign slot_free   = !out_valid_r || out_ready;
  assign scan_done   = (scan_r == SCAN_W'(CHANNEL_COUNT));
  assign scan_idx    = scan_r[IDX_W-1:0];
  assign cmd_idx     = q_item.chan[IDX_W-1:0];
  assign scan_active = alloc_r[scan_idx] && run_r[scan_idx];

  // channel values seen during the scan
  assign cnt_val = cvld_r[scan_idx] ? cnt_q_r : '0;
  assign lim_val = lvld_r[scan_idx] ? lim_q_r : '0;
  assign expire  = (cnt_val >= lim_val);
  // a new expiry pushes the held one out, which needs a free result slot
  assign eval_go = !(expire && hold_vld_r && !slot_free);

  // lowest free channel for allocate
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && q_item.cmd == CMD_TICK) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (scan_done) begin
          st_nxt = ST_FLUSH;
        end else if (scan_active) begin
          st_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          st_nxt = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r || slot_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    q_pop           = 1'b0;
    alloc_nxt       = alloc_r;
    run_nxt         = run_r;
    shot_nxt        = shot_r;
    cvld_nxt        = cvld_r;
    lvld_nxt        = lvld_r;
    scan_nxt        = scan_r;
    hold_vld_nxt    = hold_vld_r;
    hold_ch_nxt     = hold_ch_r;
    cnt_we          = 1'b0;
    lim_we          = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_channel_nxt = out_channel_r;
    out_ok_nxt      = out_ok_r;
    out_last_nxt    = out_last_r;
    unique case (st_r)
      ST_IDLE: begin
        if (q_valid && q_item.cmd == CMD_TICK) begin
          // start a scan from channel zero
          q_pop        = 1'b1;
          scan_nxt     = '0;
          hold_vld_nxt = 1'b0;
        end else if (q_valid && slot_free) begin
          // command with one status result
          q_pop           = 1'b1;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_STATUS;
          out_channel_nxt = q_item.chan;
          out_ok_nxt      = 1'b0;
          out_last_nxt    = 1'b1;
          unique case (q_item.cmd)
            CMD_ALLOC: begin
              out_channel_nxt = '0;
              if (free_found) begin
                alloc_nxt[free_idx] = 1'b1;
                out_channel_nxt     = CHAN_W'(free_idx);
                out_ok_nxt          = 1'b1;
              end
            end
            CMD_CONFIG: begin
              if (alloc_r[cmd_idx]) begin
                run_nxt[cmd_idx]  = 1'b0;
                cvld_nxt[cmd_idx] = 1'b0;
                lvld_nxt[cmd_idx] = 1'b1;
                shot_nxt[cmd_idx] = q_item.one_shot;
                lim_we            = 1'b1;
                out_ok_nxt        = 1'b1;
              end
            end
            CMD_START: begin
              if (alloc_r[cmd_idx] && !run_r[cmd_idx]) begin
                run_nxt[cmd_idx] = 1'b1;
                out_ok_nxt       = 1'b1;
              end
            end
            CMD_STOP: begin
              if (alloc_r[cmd_idx] && run_r[cmd_idx]) begin
                run_nxt[cmd_idx] = 1'b0;
                out_ok_nxt       = 1'b1;
              end
            end
            CMD_RESET: begin
              if (alloc_r[cmd_idx] && !run_r[cmd_idx]) begin
                cvld_nxt[cmd_idx] = 1'b0;
                out_ok_nxt        = 1'b1;
              end
            end
            CMD_FREE: begin
              if (alloc_r[cmd_idx] && !run_r[cmd_idx]) begin
                alloc_nxt[cmd_idx] = 1'b0;
                run_nxt[cmd_idx]   = 1'b0;
                shot_nxt[cmd_idx]  = 1'b0;
                cvld_nxt[cmd_idx]  = 1'b0;
                lvld_nxt[cmd_idx]  = 1'b0;
                out_ok_nxt         = 1'b1;
              end
            end
            default: out_ok_nxt = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        // idle channels are skipped without an evaluation step
        if (!scan_done && !scan_active) begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          scan_nxt = scan_r + SCAN_W'(1);
          if (expire) begin
            cvld_nxt[scan_idx] = 1'b0;
            if (shot_r[scan_idx]) begin
              alloc_nxt[scan_idx] = 1'b0;
              run_nxt[scan_idx]   = 1'b0;
              shot_nxt[scan_idx]  = 1'b0;
              lvld_nxt[scan_idx]  = 1'b0;
            end
            // the previous expiry is not the last one
            if (hold_vld_r) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = KIND_EXPIRY;
              out_channel_nxt = CHAN_W'(hold_ch_r);
              out_ok_nxt      = 1'b1;
              out_last_nxt    = 1'b0;
            end
            hold_vld_nxt = 1'b1;
            hold_ch_nxt  = scan_idx;
          end else begin
            cnt_we             = 1'b1;
            cvld_nxt[scan_idx] = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        // the held expiry closes the tick
        if (hold_vld_r && slot_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_EXPIRY;
          out_channel_nxt = CHAN_W'(hold_ch_r);
          out_ok_nxt      = 1'b1;
          out_last_nxt    = 1'b1;
          hold_vld_nxt    = 1'b0;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      alloc_r     <= '0;
      run_r       <= '0;
      shot_r      <= '0;
      cvld_r      <= '0;
      lvld_r      <= '0;
      scan_r      <= '0;
      hold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      alloc_r     <= alloc_nxt;
      run_r       <= run_nxt;
      shot_r      <= shot_nxt;
      cvld_r      <= cvld_nxt;
      lvld_r      <= lvld_nxt;
      scan_r      <= scan_nxt;
      hold_vld_r  <= hold_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_ch_r     <= hold_ch_nxt;
    out_kind_r    <= out_kind_nxt;
    out_channel_r <= out_channel_nxt;
    out_ok_r      <= out_ok_nxt;
    out_last_r    <= out_last_nxt;
  end

  // count and limit memories, one registered read for the scanned channel
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[scan_idx] <= cnt_val + VAL_W'(1);
    end
    if (lim_we) begin
      lim_mem[cmd_idx] <= q_item.max_value;
    end
    if (st_r == ST_READ && !scan_done) begin
      cnt_q_r <= cnt_mem[scan_idx];
      lim_q_r <= lim_mem[scan_idx];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_channel = out_channel_r;
  assign out_ok      = out_ok_r;
  assign out_last    = out_last_r;

endmodule

// ===== src/multi_channel_soft_timer_bank.sv =====
`timescale 1ns / 1ps
// Top level of the timer channel bank: command queue front end and executing back end.
// Depends on mcst_pkg, mcst_front and mcst_back.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   opcode, timer_id, max_value, one_shot
//   out_      output     out_valid / out_ready kind, channel, ok, last
//
// A command other than tick executes once it reaches the back end.
// A tick leaves the queue, then scans the channels with one count/limit memory read port:
// an idle channel is skipped in ST_READ, a running one goes through ST_READ and ST_EVAL,
// and ST_FLUSH then sends any held expiry to close the tick; the scan runs longer
// while out_ready holds back an expiry.
// Reset clears all channels at once; no clearing pass is needed.
// A two entry queue lets the input side run ahead while results wait on out_ready.
module multi_channel_soft_timer_bank #(
  parameter int CHANNEL_COUNT = mcst_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcst_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [mcst_pkg::ID_W-1:0]     in_timer_id,
  input  logic [mcst_pkg::VAL_W-1:0]    in_max_value,
  input  logic                          in_one_shot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [mcst_pkg::CHAN_W-1:0]   out_channel,
  output logic                          out_ok,
  output logic                          out_last
);
  import mcst_pkg::*;

  logic      q_valid;
  cmd_item_t q_item;
  logic      q_pop;

  // accept and classify
  mcst_front #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_timer_id  (in_timer_id),
    .in_max_value (in_max_value),
    .in_one_shot  (in_one_shot),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // execute and report
  mcst_back #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_channel (out_channel),
    .out_ok      (out_ok),
    .out_last    (out_last)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_channel_soft_timer_bank: directed and random commands.
// Depends on mcst_pkg and the multi_channel_soft_timer_bank top level.
module testbench;
  import mcst_pkg::*;

  localparam int NCH = CHANNEL_COUNT_DEF;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 225;

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] channel;
    logic              ok;
    logic              last;
  } timer_result_t;

  // shadow copy of the channel table and the results it predicts
  class timer_pool_tracker;
    bit                allocated[NCH];
    bit                running[NCH];
    bit                single_shot[NCH];
    logic [VAL_W-1:0]  tick_count[NCH];
    logic [VAL_W-1:0]  limit[NCH];
    timer_result_t     pending_results[$];
    int                errors;

    function new();
      errors = 0;
      for (int c = 0; c < NCH; c++) clear_channel(c);
    endfunction

    function void clear_channel(int c);
      allocated[c]   = 1'b0;
      running[c]     = 1'b0;
      single_shot[c] = 1'b0;
      tick_count[c]  = '0;
      limit[c]       = '0;
    endfunction

    function int lowest_free();
      for (int c = 0; c < NCH; c++) begin
        if (!allocated[c]) return c;
      end
      return -1;
    endfunction

    // work out the results of one accepted command and update the table
    function void note_command(logic [OPCODE_W-1:0] op, logic [ID_W-1:0] id,
                               logic [VAL_W-1:0] mv, logic os);
      timer_result_t burst[$];
      timer_result_t r;
      int            c;
      r.kind = KIND_STATUS;
      r.channel = id[CHAN_W-1:0];
      r.ok = 1'b0;
      r.last = 1'b1;
      if (op == OP_TICK) begin
        // channels are visited from 0 upward
        for (c = 0; c < NCH; c++) begin
          if (allocated[c] && running[c]) begin
            if (tick_count[c] >= limit[c]) begin
              r.kind = KIND_EXPIRY;
              r.channel = c[CHAN_W-1:0];
              r.ok = 1'b1;
              r.last = 1'b0;
              burst.push_back(r);
              tick_count[c] = '0;
              if (single_shot[c]) clear_channel(c);
            end else begin
              tick_count[c] = tick_count[c] + VAL_W'(1);
            end
          end
        end
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) pending_results.push_back(burst[i]);
      end else if (op == OP_ALLOC) begin
        c = lowest_free();
        if (c >= 0) begin
          allocated[c] = 1'b1;
          r.channel = c[CHAN_W-1:0];
          r.ok = 1'b1;
        end else begin
          r.channel = '0;
        end
        pending_results.push_back(r);
      end else begin
        c = int'(id);
        if (id < NCH) begin
          case (op)
            OP_CONFIG: begin
              if (allocated[c]) begin
                running[c] = 1'b0;
                tick_count[c] = '0;
                limit[c] = mv;
                single_shot[c] = os;
                r.ok = 1'b1;
              end
            end
            OP_START: begin
              if (allocated[c] && !running[c]) begin
                running[c] = 1'b1;
                r.ok = 1'b1;
              end
            end
            OP_STOP: begin
              if (allocated[c] && running[c]) begin
                running[c] = 1'b0;
                r.ok = 1'b1;
              end
            end
            OP_RESET: begin
              if (allocated[c] && !running[c]) begin
                tick_count[c] = '0;
                r.ok = 1'b1;
              end
            end
            OP_FREE: begin
              if (allocated[c] && !running[c]) begin
                clear_channel(c);
                r.ok = 1'b1;
              end
            end
            default: ;
          endcase
        end
        pending_results.push_back(r);
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 50) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted result against the oldest prediction
    task check_result(logic kind, logic [CHAN_W-1:0] channel, logic ok, logic last);
      timer_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d channel %0d ok %0d last %0d",
                                  kind, channel, ok, last));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind || channel !== want.channel ||
            ok !== want.ok || last !== want.last) begin
          report_mismatch($sformatf(
            "got kind %0d channel %0d ok %0d last %0d, want %0d %0d %0d %0d",
            kind, channel, ok, last, want.kind, want.channel, want.ok, want.last));
        end
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode;
  logic [ID_W-1:0]     in_timer_id;
  logic [VAL_W-1:0]    in_max_value;
  logic                in_one_shot;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_kind;
  logic [CHAN_W-1:0]   out_channel;
  logic                out_ok;
  logic                out_last;

  timer_pool_tracker tracker = new();
  int                items_sent = 0;
  bit                calm = 1'b0;

  multi_channel_soft_timer_bank #(
    .CHANNEL_COUNT(NCH)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_timer_id  (in_timer_id),
    .in_max_value (in_max_value),
    .in_one_shot  (in_one_shot),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_channel  (out_channel),
    .out_ok       (out_ok),
    .out_last     (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check every transfer, stall ready at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_kind, out_channel, out_ok, out_last);
    out_ready <= calm || ($urandom_range(99) >= 20);
  end

  // one command transfer, with random idle cycles ahead of it
  task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [VAL_W-1:0] mv, input logic os);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_timer_id  <= id;
    in_max_value <= mv;
    in_one_shot  <= os;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_command(op, id, mv, os);
    items_sent++;
    calm = (items_sent >= 100 && items_sent < 160);
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  function automatic logic [VAL_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 70) return VAL_W'($urandom_range(3));
    if (r < 90) return VAL_W'($urandom_range(20));
    return VAL_W'($urandom_range(65535));
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return ID_W'($urandom_range(NCH - 1));
    return ID_W'($urandom_range(255));
  endfunction

  // any single command, including broken ones
  task automatic send_random_command();
    int r;
    logic [OPCODE_W-1:0] op;
    r = $urandom_range(99);
    if (r < 12)      op = OP_ALLOC;
    else if (r < 27) op = OP_CONFIG;
    else if (r < 42) op = OP_START;
    else if (r < 50) op = OP_STOP;
    else if (r < 56) op = OP_RESET;
    else if (r < 62) op = OP_FREE;
    else if (r < 95) op = OP_TICK;
    else             op = OP_UNUSED;
    send_command(op, pick_id(), pick_limit(), 1'($urandom_range(1)));
  endtask

  // allocate, configure and start a channel, then let it run
  task automatic run_channel_lifecycle();
    int c;
    c = tracker.lowest_free();
    if (c < 0) begin
      c = $urandom_range(NCH - 1);
      send_command(OP_STOP, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
      send_command(OP_FREE, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
      c = tracker.lowest_free();
    end
    send_command(OP_ALLOC, ID_W'($urandom_range(255)), VAL_W'($urandom_range(65535)),
                 1'($urandom_range(1)));
    send_command(OP_CONFIG, ID_W'(c), VAL_W'($urandom_range(4)), 1'($urandom_range(1)));
    send_command(OP_START, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
    repeat ($urandom_range(1, 6))
      send_command(OP_TICK, ID_W'($urandom_range(255)), VAL_W'($urandom_range(65535)),
                   1'($urandom_range(1)));
    if ($urandom_range(3) == 0) begin
      send_command(OP_STOP, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
      send_command(OP_RESET, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
      send_command(OP_FREE, ID_W'(c), VAL_W'($urandom_range(65535)), 1'($urandom_range(1)));
    end
  endtask

  // main sequence
  initial begin
    bit paused;
    paused       = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= OP_ALLOC;
    in_timer_id  <= '0;
    in_max_value <= '0;
    in_one_shot  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the bank, then one allocate with no free channel
    for (int i = 0; i < NCH; i++)
      send_command(OP_ALLOC, (i % 2) ? 8'hFF : 8'h00, 16'hFFFF, 1'(i % 2));
    send_command(OP_ALLOC, 8'h00, 16'h0000, 1'b0);
    // limit extremes, one-shot, id out of range
    send_command(OP_CONFIG, 8'd0, 16'h0000, 1'b1);
    send_command(OP_CONFIG, 8'd1, 16'hFFFF, 1'b0);
    send_command(OP_CONFIG, 8'hFF, 16'h0001, 1'b0);
    // start, and start of a running channel
    send_command(OP_START, 8'd0, 16'hFFFF, 1'b1);
    send_command(OP_START, 8'd1, 16'h0000, 1'b0);
    send_command(OP_START, 8'd0, 16'h0000, 1'b0);
    // one-shot expiry on the first tick, then a tick with no expiry
    send_command(OP_TICK, 8'hFF, 16'hFFFF, 1'b1);
    send_command(OP_TICK, 8'h00, 16'h0000, 1'b0);
    // stop, reset and free, each twice or out of range
    send_command(OP_STOP, 8'd1, 16'h0000, 1'b0);
    send_command(OP_STOP, 8'd1, 16'h0000, 1'b0);
    send_command(OP_RESET, 8'd1, 16'hFFFF, 1'b1);
    send_command(OP_RESET, 8'd8, 16'h0000, 1'b0);
    send_command(OP_FREE, 8'd1, 16'h0000, 1'b0);
    send_command(OP_FREE, 8'd1, 16'h0000, 1'b0);
    // unused opcode, then reclaim a freed channel
    send_command(OP_UNUSED, 8'hFF, 16'hFFFF, 1'b1);
    send_command(OP_ALLOC, 8'h7F, 16'h0000, 1'b0);

    // random part: mostly channel lifecycles, some loose commands
    while (items_sent < 25 + RANDOM_ITEMS) begin
      if ($urandom_range(99) < 45) run_channel_lifecycle();
      else send_random_command();
      if (!paused && items_sent >= 170) begin
        drain_results();
        paused = 1'b1;
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (tracker.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
